/* rtl/bsfla_pkg.sv */
`timescale 1ns / 1ps

package bsfla_pkg;

   // Pool geometry; 16 slots, so the slot fields are 4 bits wide
   localparam int SLOTS  = 16;
   localparam int SLOT_W = $clog2(SLOTS);

   localparam int CMD_W  = 2;
   localparam int LBA_W  = 32;
   localparam int TAG_W  = 32;
   localparam int STAT_W = 2;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FIND    = 2'd2;

   // Status codes
   localparam logic [STAT_W-1:0] STATUS_OK         = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_NO_FREE    = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_NOT_FOUND  = 2'd2;
   localparam logic [STAT_W-1:0] STATUS_NOT_IN_USE = 2'd3;

   typedef logic [SLOT_W-1:0] slot_type;

endpackage

/* rtl/buffer_slot_free_list_allocator.sv */
`timescale 1ns / 1ps

// Channel   Ports                                                                      Dir
// --------  -------------------------------------------------------------------------  ---
// request   req_valid/req_ready, req_cmd, req_start_lba, req_request_tag, req_slot_in  in
// response  rsp_valid/rsp_ready, rsp_slot_out, rsp_status                              out
//
// A request is taken in S_IDLE and executed from S_EXEC in the next: allocate and release finish
// in S_EXEC; find walks the slots one per cycle in S_SCAN through a single shared 32-bit tag
// comparator and stops at the first hit or after the last slot.
// Reset is synchronous and restores the free order slot 0 .. SLOTS-1.
// A finished result waits in place while the response register is still full, and state
// changes commit only together with the response. Command code 3 gets no response.

module buffer_slot_free_list_allocator (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [bsfla_pkg::CMD_W-1:0]     req_cmd,
   input  logic [bsfla_pkg::LBA_W-1:0]     req_start_lba,
   input  logic [bsfla_pkg::TAG_W-1:0]     req_request_tag,
   input  logic [bsfla_pkg::SLOT_W-1:0]    req_slot_in,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [bsfla_pkg::SLOT_W-1:0]    rsp_slot_out,
   output logic [bsfla_pkg::STAT_W-1:0]    rsp_status
);
   import bsfla_pkg::*;

   // Sequencer states
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_SCAN = 2'd2;

   localparam slot_type LAST_SLOT = SLOT_W'(SLOTS - 1);

   logic [1:0]        state_ff, state_in;
   logic [CMD_W-1:0]  cmd_ff;
   logic [LBA_W-1:0]  lba_ff;
   logic [TAG_W-1:0]  tag_ff;
   slot_type          slot_ff;
   slot_type          scan_idx_ff, scan_idx_in;

   // Free list
   slot_type          next_link_ff [SLOTS];
   slot_type          free_head_ff, free_head_in;
   slot_type          free_tail_ff, free_tail_in;
   logic              free_empty_ff, free_empty_in;
   logic [SLOTS-1:0]  in_use_ff, in_use_in;

   // Per-slot payload
   logic [LBA_W-1:0]  lba_store_ff [SLOTS];
   logic [TAG_W-1:0]  tag_store_ff [SLOTS];

   // Response register
   logic              rsp_valid_ff, rsp_valid_in;
   slot_type          rsp_slot_ff, rsp_slot_in;
   logic [STAT_W-1:0] rsp_status_ff, rsp_status_in;

   logic              accept;
   logic              out_free;
   logic              res_done;
   slot_type          res_slot;
   logic [STAT_W-1:0] res_status;
   logic              commit;
   logic              do_alloc;
   logic              do_release;
   logic              scan_hit;

   assign req_ready    = (state_ff == S_IDLE);
   assign accept       = req_valid && req_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_slot_out = rsp_slot_ff;
   assign rsp_status   = rsp_status_ff;

   // The response register can take a new result when empty or draining now
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Shared comparator: one slot's tag per cycle
   assign scan_hit = in_use_ff[scan_idx_ff] && (tag_store_ff[scan_idx_ff] == tag_ff);

   always_comb begin
      state_in    = state_ff;
      scan_idx_in = scan_idx_ff;
      res_done    = 1'b0;
      res_slot    = '0;
      res_status  = STATUS_OK;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            case (cmd_ff)
               CMD_ALLOC: begin
                  res_done = 1'b1;
                  if (free_empty_ff) begin
                     res_status = STATUS_NO_FREE;
                  end else begin
                     res_slot = free_head_ff;
                  end
               end
               CMD_RELEASE: begin
                  res_done = 1'b1;
                  if (!in_use_ff[slot_ff]) begin
                     res_status = STATUS_NOT_IN_USE;
                  end
               end
               CMD_FIND: begin
                  state_in    = S_SCAN;
                  scan_idx_in = '0;
               end
               default: begin
                  // no-op: drop without a response
                  state_in = S_IDLE;
               end
            endcase
         end
         S_SCAN: begin
            if (scan_hit) begin
               res_done = 1'b1;
               res_slot = scan_idx_ff;
            end else if (scan_idx_ff == LAST_SLOT) begin
               res_done   = 1'b1;
               res_status = STATUS_NOT_FOUND;
            end else begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      // hold a finished result until the response register frees up
      if (res_done && out_free) begin
         state_in = S_IDLE;
      end
   end

   assign commit     = res_done && out_free;
   assign do_alloc   = commit && (state_ff == S_EXEC) && (cmd_ff == CMD_ALLOC)
                       && !free_empty_ff;
   assign do_release = commit && (state_ff == S_EXEC) && (cmd_ff == CMD_RELEASE)
                       && in_use_ff[slot_ff];

   // Free-list bookkeeping
   always_comb begin
      free_head_in  = free_head_ff;
      free_tail_in  = free_tail_ff;
      free_empty_in = free_empty_ff;
      in_use_in     = in_use_ff;
      if (do_alloc) begin
         in_use_in[free_head_ff] = 1'b1;
         if (free_head_ff == free_tail_ff) begin
            free_empty_in = 1'b1;
         end else begin
            free_head_in = next_link_ff[free_head_ff];
         end
      end
      if (do_release) begin
         in_use_in[slot_ff] = 1'b0;
         free_tail_in       = slot_ff;
         if (free_empty_ff) begin
            free_head_in  = slot_ff;
            free_empty_in = 1'b0;
         end
      end
   end

   // Response register: load on commit, drop once taken
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_status_in = rsp_status_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (commit) begin
         rsp_valid_in  = 1'b1;
         rsp_slot_in   = res_slot;
         rsp_status_in = res_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         free_head_ff  <= '0;
         free_tail_ff  <= LAST_SLOT;
         free_empty_ff <= 1'b0;
         in_use_ff     <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         free_head_ff  <= free_head_in;
         free_tail_ff  <= free_tail_in;
         free_empty_ff <= free_empty_in;
         in_use_ff     <= in_use_in;
      end
   end

   // Successor links: reset to the ascending order, last slot wraps to zero
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            next_link_ff[i] <= (i == SLOTS - 1) ? '0 : SLOT_W'(i + 1);
         end
      end else if (do_release && !free_empty_ff) begin
         next_link_ff[free_tail_ff] <= slot_ff;
      end
   end

   // Payload registers, no reset
   always_ff @(posedge clock) begin
      scan_idx_ff   <= scan_idx_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_status_ff <= rsp_status_in;
      if (accept) begin
         cmd_ff  <= req_cmd;
         lba_ff  <= req_start_lba;
         tag_ff  <= req_request_tag;
         slot_ff <= req_slot_in;
      end
   end

   // Slot payload stores, written on allocate
   always_ff @(posedge clock) begin
      if (do_alloc) begin
         lba_store_ff[free_head_ff] <= lba_ff;
         tag_store_ff[free_head_ff] <= tag_ff;
      end
   end

endmodule
